// ===== rtl/core/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// shared types and constants for the smallest factor sum block
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned InBits       = 64;
  localparam int unsigned FactorBits   = 32;
  localparam int unsigned SumBits      = 64;

  localparam logic [FactorBits-1:0] FirstCand = FactorBits'(5);
  localparam logic [FactorBits-1:0] CandStep  = FactorBits'(6);
  localparam logic [FactorBits-1:0] PairGap   = FactorBits'(2);
  localparam logic [FactorBits-1:0] FacTwo    = FactorBits'(2);
  localparam logic [FactorBits-1:0] FacThree  = FactorBits'(3);
  localparam int unsigned           SmallMax  = 3;

  typedef enum logic {
    DIV_CAND,
    DIV_PAIR
  } div_sel_e;

  typedef enum logic [2:0] {
    FAC_ZERO,
    FAC_TWO,
    FAC_THREE,
    FAC_CAND,
    FAC_PAIR
  } fac_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     cand_init;
    logic     cand_step;
    logic     sq_en;
    logic     fac_set;
    fac_sel_e fac_sel;
    logic     commit;
  } sfs_cmd_t;

  typedef struct packed {
    logic tiny;
    logic even;
    logic three_div;
    logic div_busy;
    logic rem_zero;
    logic sq_over;
  } sfs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/smallest_factor_sum_top.sv =====
// ----------------------------------------------------------------------------
// smallest_factor_sum_top
// smallest prime factor by 6k+-1 trial division, with a running factor sum
// ----------------------------------------------------------------------------
// each input word is a signed number (low VALUE_BITS bits, sign extended);
// the block returns its smallest prime factor (0 for a prime or a value of
// 3 or less) and the wrapping sum of all factors since reset. one word is
// worked on at a time. divisibility by 2 and 3 is decided combinationally;
// the candidate remainder unit is bit serial, so the time taken is data
// dependent: shortest for a value of 3 or less or one that 2 or 3 divides,
// and growing with the number of candidate pairs tried, up to sqrt(value)/6
// pairs for a prime. a finished word waits in the output register while the
// next input word is taken.
`default_nettype none

module smallest_factor_sum_top import sfs_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [InBits-1:0]     value_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [FactorBits-1:0]      factor_o,
  output logic [SumBits-1:0]         running_sum_o
);

  // command and status between sequencer and datapath
  sfs_cmd_t  cmd;
  sfs_stat_t stat;

  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // operand, candidate, squarer, remainder unit and sum register
  sfs_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .factor_o      (factor_o),
    .running_sum_o (running_sum_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sfs_dp.sv =====
// ----------------------------------------------------------------------------
// sfs_dp
// datapath: operand, candidate, square, bit-serial remainder unit, sum
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_dp import sfs_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [InBits-1:0]     value_i,
  input  wire sfs_cmd_t              cmd_i,
  output sfs_stat_t                  stat_o,
  output logic [FactorBits-1:0]      factor_o,
  output logic [SumBits-1:0]         running_sum_o
);

  localparam int unsigned IdxBits = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0]   n_q;
  logic [FactorBits-1:0]   cand_q;
  logic [2*FactorBits-1:0] sq_q;
  logic [FactorBits-1:0]   dvs_q;
  logic [FactorBits-1:0]   rem_q, rem_d;
  logic [IdxBits-1:0]      idx_q;
  logic                    busy_q;
  logic [FactorBits-1:0]   pend_q;
  logic [FactorBits-1:0]   factor_q;
  logic [SumBits-1:0]      sum_q;
  logic [FactorBits:0]     shifted;
  logic [FactorBits-1:0]   pair;
  logic [InBits-1:0]       n_ext;
  logic [2:0]              m3_a [16];
  logic [3:0]              m3_b [8];
  logic [4:0]              m3_c [4];
  logic [5:0]              m3_d [2];
  logic [6:0]              m3_sum;
  logic [3:0]              m3_fold;

  assign pair    = cand_q + PairGap;
  assign shifted = {rem_q, n_q[idx_q]};

  // one restoring step per cycle
  always_comb begin
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = FactorBits'(shifted - {1'b0, dvs_q});
    end else begin
      rem_d = shifted[FactorBits-1:0];
    end
  end

  // divisibility by three: base-4 digit sum in a tree, then a small fold
  assign n_ext = InBits'(n_q);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      m3_a[i] = 3'(n_ext[4*i +: 2]) + 3'(n_ext[4*i+2 +: 2]);
    end
    for (int i = 0; i < 8; i++) begin
      m3_b[i] = 4'(m3_a[2*i]) + 4'(m3_a[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      m3_c[i] = 5'(m3_b[2*i]) + 5'(m3_b[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      m3_d[i] = 6'(m3_c[2*i]) + 6'(m3_c[2*i+1]);
    end
    m3_sum  = 7'(m3_d[0]) + 7'(m3_d[1]);
    m3_fold = 4'(m3_sum[1:0]) + 4'(m3_sum[3:2]) + 4'(m3_sum[5:4]) + 4'(m3_sum[6]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
      end else if (busy_q && idx_q == '0) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        sum_q <= sum_q + SumBits'(pend_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= value_i[VALUE_BITS-1:0];
    end
    if (cmd_i.cand_init) begin
      cand_q <= FirstCand;
    end else if (cmd_i.cand_step) begin
      cand_q <= cand_q + CandStep;
    end
    if (cmd_i.sq_en) begin
      sq_q <= cand_q * cand_q;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      idx_q <= IdxBits'(VALUE_BITS - 1);
      case (cmd_i.div_sel)
        DIV_CAND: dvs_q <= cand_q;
        DIV_PAIR: dvs_q <= pair;
        default:  dvs_q <= cand_q;
      endcase
    end else if (busy_q) begin
      rem_q <= rem_d;
      if (idx_q != '0) begin
        idx_q <= idx_q - 1'b1;
      end
    end
    if (cmd_i.fac_set) begin
      case (cmd_i.fac_sel)
        FAC_ZERO:  pend_q <= '0;
        FAC_TWO:   pend_q <= FacTwo;
        FAC_THREE: pend_q <= FacThree;
        FAC_CAND:  pend_q <= cand_q;
        FAC_PAIR:  pend_q <= pair;
        default:   pend_q <= '0;
      endcase
    end
    if (cmd_i.commit) begin
      factor_q <= pend_q;
    end
  end

  assign stat_o.tiny      = n_q[VALUE_BITS-1] || (n_q <= VALUE_BITS'(SmallMax));
  assign stat_o.even      = ~n_q[0];
  assign stat_o.three_div = (m3_fold inside {4'd0, 4'd3, 4'd6, 4'd9});
  assign stat_o.div_busy  = busy_q;
  assign stat_o.rem_zero  = (rem_q == '0);
  assign stat_o.sq_over   = (sq_q > (2*FactorBits)'(n_q));

  assign factor_o      = factor_q;
  assign running_sum_o = sum_q + SumBits'(0);

endmodule

`default_nettype wire

// ===== rtl/core/sfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfs_ctrl
// controller: sequences the input handshake, the trial division and the output handshake
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ctrl import sfs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire sfs_stat_t stat_i,
  output sfs_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_SQ,
    S_CMP,
    S_WA,
    S_WB,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat_i.tiny) begin
          cmd_o.fac_set = 1'b1;
          cmd_o.fac_sel = FAC_ZERO;
          state_d       = S_DONE;
        end else if (stat_i.even) begin
          cmd_o.fac_set = 1'b1;
          cmd_o.fac_sel = FAC_TWO;
          state_d       = S_DONE;
        end else if (stat_i.three_div) begin
          cmd_o.fac_set = 1'b1;
          cmd_o.fac_sel = FAC_THREE;
          state_d       = S_DONE;
        end else begin
          cmd_o.cand_init = 1'b1;
          state_d         = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (stat_i.sq_over) begin
          cmd_o.fac_set = 1'b1;
          cmd_o.fac_sel = FAC_ZERO;
          state_d       = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_CAND;
          state_d         = S_WA;
        end
      end
      S_WA: begin
        if (!stat_i.div_busy) begin
          if (stat_i.rem_zero) begin
            cmd_o.fac_set = 1'b1;
            cmd_o.fac_sel = FAC_CAND;
            state_d       = S_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_PAIR;
            state_d         = S_WB;
          end
        end
      end
      S_WB: begin
        if (!stat_i.div_busy) begin
          if (stat_i.rem_zero) begin
            cmd_o.fac_set = 1'b1;
            cmd_o.fac_sel = FAC_PAIR;
            state_d       = S_DONE;
          end else begin
            cmd_o.cand_step = 1'b1;
            state_d         = S_SQ;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== verif/tb_smallest_factor_sum_top.sv =====
// ----------------------------------------------------------------------------
// tb_smallest_factor_sum_top
// self-checking bench for the smallest factor sum block
// ----------------------------------------------------------------------------
// words are pushed with random gaps and the result side stalls at random.
// a scoreboard predicts each factor and the running sum, then checks results
// in order. random values keep trial division short: large values carry a
// known small prime, and primes are only drawn from small numbers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_smallest_factor_sum_top;
  import sfs_pkg::*;

  localparam int unsigned VBits     = ValueBitsDef;
  localparam int          WatchMax  = 100000;
  localparam int          HoldLen   = 400;
  localparam int          TailWait  = 300;

  typedef struct {
    logic [FactorBits-1:0] factor;
    logic [SumBits-1:0]    sum;
  } sfs_result_t;

  // prediction and in-order checking of results
  class sfs_scoreboard;
    logic [SumBits-1:0] factor_total;
    sfs_result_t        pending_q[$];
    int                 fails;

    function new();
      factor_total = '0;
      fails = 0;
    endfunction

    function automatic logic [63:0] sign_extend(logic [InBits-1:0] raw);
      logic [63:0] v;
      v = 64'(raw);
      if (VBits < 64) begin
        v = v & ((64'd1 << VBits) - 1);
        if (v[VBits-1]) v = v | ~((64'd1 << VBits) - 1);
      end
      return v;
    endfunction

    function automatic logic [FactorBits-1:0] least_prime_factor(logic [63:0] n);
      logic [63:0] c;
      if (n[63] || n <= 64'(SmallMax)) return '0;
      if (n % 2 == 0) return FacTwo;
      if (n % 3 == 0) return FacThree;
      for (c = 64'd5; c * c <= n; c += 6) begin
        if (n % c == 0) return c[FactorBits-1:0];
        if (n % (c + 2) == 0) return FactorBits'(c + 2);
      end
      return '0;
    endfunction

    function void note_value(logic [InBits-1:0] raw);
      sfs_result_t r;
      r.factor = least_prime_factor(sign_extend(raw));
      factor_total = factor_total + SumBits'(r.factor);
      r.sum = factor_total;
      pending_q.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      fails++;
    endtask

    task check_result(logic [FactorBits-1:0] f, logic [SumBits-1:0] s);
      sfs_result_t r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word factor=%0d sum=%0d", f, s));
        return;
      end
      r = pending_q.pop_front();
      if (f !== r.factor)
        report($sformatf("factor got %0d want %0d", f, r.factor));
      if (s !== r.sum)
        report($sformatf("running sum got %0h want %0h", s, r.sum));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [InBits-1:0]     value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [FactorBits-1:0] factor_o;
  logic [SumBits-1:0]    running_sum_o;

  sfs_scoreboard sb = new();

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // bumping this asks the receiver for one long hold-off
  int hold_seq = 0;
  int watch_cnt = 0;

  smallest_factor_sum_top #(.VALUE_BITS(VBits)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .factor_o      (factor_o),
    .running_sum_o (running_sum_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stalls, plus a long hold-off counted here
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(factor_o, running_sum_o);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      watch_cnt <= 0;
    end else if (watch_cnt >= WatchMax) begin
      $display("smallest_factor_sum_top test failed");
      $finish;
    end else begin
      watch_cnt <= watch_cnt + 1;
    end
  end

  // offer one word, hold it until taken; valid stays high afterwards
  task automatic send_word(logic [InBits-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_value(v);
  endtask

  // stop offering, then wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // random value shaped so trial division stays short
  function automatic logic [InBits-1:0] pick_value();
      logic [63:0] m;
      logic [63:0] p;
      int          kind;
      int unsigned primes[10] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 97};
      kind = $urandom_range(9);
      m = {$urandom, $urandom};
      case (kind)
        0, 1: return m | 64'h8000_0000_0000_0000;               // negative
        2: return 64'($signed($urandom_range(50))) - 64'd10;     // around the small edge
        3: return {m[63:1], 1'b0} & 64'h7fff_ffff_ffff_ffff;     // even
        4: return 64'(($urandom >> 2) * 3);                      // multiple of three
        5, 6: return 64'($urandom_range(16383, 4));              // may be prime
        default: begin
          p = 64'(primes[$urandom_range(9)]);
          return (m >> 8) * p;                                   // small factor present
        end
      endcase
  endfunction

  initial begin
    logic [InBits-1:0] directed_q[$];
    int phase_idle[4]  = '{0, 85, 0, 9};
    int phase_stall[4] = '{0, 0, 85, 9};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, the small and negative edge, each divisor path, primes
    directed_q = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, '1,
                   64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                   64'd9, 64'd25, 64'd35, 64'd49, 64'd5, 64'd7, 64'd97,
                   64'd121, 64'd143, 64'd289, 64'd10403, 64'd16381,
                   64'h4000_0000_0000_0000, 64'h5555_5555_5555_5555,
                   64'haaaa_aaaa_aaaa_aaaa, 64'd3 * 64'h0aaa_aaaa_aaaa_aaab};
    foreach (directed_q[i]) send_word(directed_q[i]);

    for (int ph = 0; ph < 4; ph++) begin
      // sender pauses until everything so far is back
      drain_results();
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      // long receiver hold-off while words keep coming
      if (ph == 1) hold_seq++;
      for (int k = 0; k < 29; k++) send_word(pick_value());
    end
    in_valid_i <= 1'b0;

    drain_results();
    repeat (TailWait) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending_q.size() == 0) begin
      $display("smallest_factor_sum_top test passed");
    end else begin
      $display("smallest_factor_sum_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sfs_pkg.sv
rtl/core/sfs_dp.sv
rtl/core/sfs_ctrl.sv
rtl/core/smallest_factor_sum_top.sv
verif/tb_smallest_factor_sum_top.sv
